>>> rtl/core/preemptive_lifo_task_order_defines.svh
// Assertion macros shared by the scheduler RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the using module.
`ifndef PREEMPTIVE_LIFO_TASK_ORDER_DEFINES_SVH
`define PREEMPTIVE_LIFO_TASK_ORDER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PLTO_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLTO_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/plto_pkg.sv
// Shared types and field widths for the preemptive LIFO task order block.
// No dependencies; used by the front queue, the scheduler and the top level.
package plto_pkg;

	localparam int ID_W  = 10;
	localparam int MIN_W = 11;
	localparam int DUR_W = 10;

	// Item kind as decided by the front.
	typedef enum logic {
		K_JOB   = 1'b0,
		K_FLUSH = 1'b1
	} kind_t;

	// One classified input item.
	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   job_id;
		logic [MIN_W-1:0]  start_minute;
		logic [DUR_W-1:0]  duration;
	} item_t;

	// One result word.
	typedef struct packed {
		logic              overflow;
		logic              last;
		logic [ID_W-1:0]   done_id;
	} result_t;

endpackage

>>> rtl/core/preemptive_lifo_task_order.sv
// Top level of the preemptive LIFO task order block: front queue and scheduler.
// Depends on plto_pkg, plto_front and plto_back.
//
//  Channel  Direction  Word contents (lowest bit first)
//  s_*      in         tdata: job_id, start_minute, duration; tuser: op
//  m_*      out        tdata: done_id; tlast: last; tuser: overflow
//
// A job that starts or preempts is taken in the idle state as it leaves the queue.
// A job that ends the running one goes through the wait, eval and last states, with a
// wait and an eval per resumed stacked job, and a flush likewise resumes every stacked job:
// the wait state lets the stack memory's registered read port settle on the new top entry.
// Reset clears control state at once; stack contents are not cleared and need no pass.
// Words are accepted into the two-entry queue while a result waits on the output.
module preemptive_lifo_task_order #(
	parameter int STACK_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [9:0] job_id, [20:10] start_minute, [30:21] duration
	input  logic [0:0]  s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [9:0] done_id
	output logic        m_tlast,
	output logic [0:0]  m_tuser    // [0] overflow
);
	import plto_pkg::*;

	logic    item_valid;
	item_t   item;
	logic    item_pop;
	result_t out_word;

	plto_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	plto_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_word   (out_word)
	);

	// Pack the result word onto the output channel.
	assign m_tdata = {{(16 - ID_W){1'b0}}, out_word.done_id};
	assign m_tlast = out_word.last;
	assign m_tuser = out_word.overflow;

endmodule

>>> rtl/core/plto_front.sv
// Front part: takes input words, classifies them and holds them in a two-entry queue.
// Depends on plto_pkg.
module plto_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,
	input  logic [0:0]            s_tuser,
	output logic                  item_valid,
	output plto_pkg::item_t       item,
	input  logic                  item_pop
);
	import plto_pkg::*;

	localparam int START_LO = ID_W;
	localparam int DUR_LO   = ID_W + MIN_W;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      in_item;
	logic       push;
	logic       pop;

	// Classify the incoming word.
	always_comb begin
		in_item.kind         = s_tuser[0] ? K_FLUSH : K_JOB;
		in_item.job_id       = s_tdata[ID_W-1:0];
		in_item.start_minute = s_tdata[START_LO +: MIN_W];
		in_item.duration     = s_tdata[DUR_LO +: DUR_W];
	end

	assign s_tready   = (cnt_q != 2'd2);
	assign push       = s_tvalid && s_tready;
	assign item_valid = (cnt_q != 2'd0);
	assign pop        = item_pop && item_valid;
	assign item       = slot_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/core/plto_back.sv
// Back part: running job, stack of preempted jobs in a memory, and the result register.
// Depends on plto_pkg and the assertion macros header.
`include "preemptive_lifo_task_order_defines.svh"

module plto_back #(
	parameter int STACK_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  plto_pkg::item_t       item,
	output logic                  item_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output plto_pkg::result_t     out_word
);
	import plto_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
	localparam int PAD_W = MIN_W - DUR_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WAIT,
		S_EVAL,
		S_LAST
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [DUR_W-1:0] left;
	} entry_t;

	state_t            state_q;
	logic              run_valid_q;
	logic [ID_W-1:0]   run_id_q;
	logic [MIN_W-1:0]  run_start_q;
	logic [DUR_W-1:0]  run_left_q;
	logic [CW-1:0]     cnt_q;
	logic              ovf_q;
	logic [MIN_W-1:0]  now_q;
	logic [MIN_W-1:0]  start_q;
	logic              flush_q;
	logic              hold_valid_q;
	logic [ID_W-1:0]   hold_id_q;
	logic              out_valid_q;
	result_t           out_word_q;

	entry_t            mem_q [STACK_DEPTH];
	entry_t            rd_q;

	logic              out_free;
	logic [MIN_W:0]    run_end;
	logic              run_fits;
	logic [MIN_W-1:0]  run_ran;
	logic [DUR_W-1:0]  run_left_cut;
	logic              stack_full;
	logic              have_top;
	logic [MIN_W:0]    top_end;
	logic              top_fits;
	logic [MIN_W-1:0]  top_gap;
	logic [DUR_W-1:0]  top_left_cut;
	logic              emit_word;
	logic              take;
	logic              push;
	logic              cut;
	logic              we;
	logic [AW-1:0]     waddr;
	entry_t            wdata;
	logic [AW-1:0]     top_addr;

	// Fit checks and remaining-time updates.
	always_comb begin
		out_free     = !out_valid_q || out_ready;
		run_end      = {1'b0, run_start_q} + {{PAD_W{1'b0}}, run_left_q};
		run_fits     = run_end <= {1'b0, item.start_minute};
		run_ran      = item.start_minute - run_start_q;
		run_left_cut = (item.start_minute > run_start_q) ?
			run_left_q - DUR_W'(run_ran) : run_left_q;
		stack_full   = (cnt_q == DEPTH_C);
		have_top     = (cnt_q != '0);
		top_addr     = AW'(cnt_q - 1'b1);
		top_end      = {1'b0, now_q} + {{PAD_W{1'b0}}, rd_q.left};
		top_fits     = flush_q || (top_end <= {1'b0, start_q});
		top_gap      = start_q - now_q;
		top_left_cut = rd_q.left - DUR_W'(top_gap);
		// A held word leaves when the output register is free, in eval with a fitting top or in last.
		emit_word    = hold_valid_q && out_free &&
			(((state_q == S_EVAL) && have_top && top_fits) || (state_q == S_LAST));
	end

	// Stack write port: push of a preempted job, or trim of the top entry.
	always_comb begin
		take  = (state_q == S_IDLE) && item_valid;
		push  = take && (item.kind == K_JOB) && run_valid_q && !run_fits && !stack_full;
		cut   = (state_q == S_EVAL) && have_top && !top_fits;
		we    = push || cut;
		waddr = push ? AW'(cnt_q) : top_addr;
		wdata = push ? entry_t'{id: run_id_q, left: run_left_cut}
			: entry_t'{id: rd_q.id, left: top_left_cut};
	end

	assign item_pop  = take;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// Stack memory with a registered read of the top entry.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (have_top) begin
			rd_q <= mem_q[top_addr];
		end
	end

	// Scheduler sequence, job state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			run_valid_q  <= 1'b0;
			run_id_q     <= '0;
			run_start_q  <= '0;
			run_left_q   <= '0;
			cnt_q        <= '0;
			ovf_q        <= 1'b0;
			now_q        <= '0;
			start_q      <= '0;
			flush_q      <= 1'b0;
			hold_valid_q <= 1'b0;
			hold_id_q    <= '0;
			out_valid_q  <= 1'b0;
			out_word_q   <= '0;
		end else begin
			if (emit_word) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						if (item.kind == K_FLUSH) begin
							flush_q     <= 1'b1;
							run_valid_q <= 1'b0;
							if (run_valid_q) begin
								hold_valid_q <= 1'b1;
								hold_id_q    <= run_id_q;
							end
							state_q <= S_WAIT;
						end else begin
							flush_q     <= 1'b0;
							run_valid_q <= 1'b1;
							run_id_q    <= item.job_id;
							run_start_q <= item.start_minute;
							run_left_q  <= item.duration;
							if (run_valid_q) begin
								if (run_fits) begin
									hold_valid_q <= 1'b1;
									hold_id_q    <= run_id_q;
									now_q        <= run_end[MIN_W-1:0];
									start_q      <= item.start_minute;
									state_q      <= S_WAIT;
								end else if (stack_full) begin
									ovf_q <= 1'b1;
								end else begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
						end
					end
				end
				S_WAIT: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (!have_top || !top_fits) begin
						state_q <= S_LAST;
					end else if (out_free || !hold_valid_q) begin
						// Resume the top job: the held one is not the last word.
						if (hold_valid_q) begin
							out_word_q  <= result_t'{overflow: ovf_q, last: 1'b0,
								done_id: hold_id_q};
						end
						hold_valid_q <= 1'b1;
						hold_id_q    <= rd_q.id;
						now_q        <= top_end[MIN_W-1:0];
						cnt_q        <= cnt_q - 1'b1;
						state_q      <= S_WAIT;
					end
				end
				S_LAST: begin
					if (!hold_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_word_q   <= result_t'{overflow: ovf_q, last: 1'b1,
							done_id: hold_id_q};
						hold_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PLTO_IMPLIES(a_cnt_range, 1'b1, cnt_q <= DEPTH_C, "stack count beyond depth")
	`PLTO_NEXT(a_ovf_sticky, ovf_q, ovf_q, "overflow flag cleared")
	`PLTO_IMPLIES(a_idle_empty, state_q == S_IDLE, !hold_valid_q, "held word left at idle")
	`PLTO_IMPLIES(a_eval_read, state_q == S_EVAL, $past(state_q) == S_WAIT || $past(state_q) == S_EVAL, "top entry checked before read settled")

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the preemptive LIFO task order block.
// Depends on plto_pkg and preemptive_lifo_task_order; predicts the job completion order.
module tb;
	import plto_pkg::*;

	localparam int STACK_DEPTH = 32;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 100;

	// Tracks the scheduler state and holds the job ids expected to finish, oldest first.
	class completion_tracker;
		int               depth;
		int               errors;
		bit               run_valid;
		logic [ID_W-1:0]  run_id;
		int               run_start;
		int               run_left;
		logic [ID_W-1:0]  held_id[64];
		int               held_left[64];
		int               held_count;
		bit               overflow_seen;
		result_t          finish_order[$];

		function new(int stack_depth);
			depth = stack_depth;
			errors = 0;
			run_valid = 0;
			run_id = '0;
			run_start = 0;
			run_left = 0;
			held_count = 0;
			overflow_seen = 0;
		endfunction

		function void add_finished(logic [ID_W-1:0] id);
			result_t r;
			r = '0;
			r.done_id = id;
			finish_order.insert(finish_order.size(), r);
		endfunction

		// Advances the scheduler by one accepted word and queues the jobs it finishes.
		function void note_item(kind_t op, logic [ID_W-1:0] id, logic [MIN_W-1:0] st,
			logic [DUR_W-1:0] dur);
			int first_new;
			int now;
			int start_i;
			int top;
			first_new = finish_order.size();
			start_i = int'(st);
			if (op == K_FLUSH) begin
				if (run_valid)
					add_finished(run_id);
				while (held_count > 0) begin
					held_count--;
					add_finished(held_id[held_count]);
				end
				run_valid = 0;
			end else begin
				if (run_valid) begin
					now = run_start + run_left;
					if (now <= start_i) begin
						// The running job ends; stacked jobs resume while they fit.
						add_finished(run_id);
						while (held_count > 0) begin
							top = held_count - 1;
							if (now + held_left[top] <= start_i) begin
								add_finished(held_id[top]);
								now += held_left[top];
								held_count = top;
							end else begin
								held_left[top] -= start_i - now;
								break;
							end
						end
					end else begin
						// The running job is preempted and goes on the stack if there is room.
						if (start_i > run_start)
							run_left -= start_i - run_start;
						if (held_count < depth) begin
							held_id[held_count] = run_id;
							held_left[held_count] = run_left;
							held_count++;
						end else begin
							overflow_seen = 1;
						end
					end
				end
				run_valid = 1;
				run_id = id;
				run_start = start_i;
				run_left = int'(dur);
			end
			for (int k = first_new; k < finish_order.size(); k++)
				finish_order[k].overflow = overflow_seen;
			if (finish_order.size() > first_new)
				finish_order[finish_order.size() - 1].last = 1'b1;
		endfunction

		// Compares one received word with the oldest expected finish.
		function void check_done(logic [ID_W-1:0] id, logic lst, logic ovf);
			result_t want;
			if (finish_order.size() == 0) begin
				$error("result with no expectation waiting: done_id %0d", id);
				errors++;
				return;
			end
			want = finish_order.pop_front();
			if (id !== want.done_id) begin
				$error("done_id mismatch: expected %0d, got %0d", want.done_id, id);
				errors++;
			end
			if (lst !== want.last) begin
				$error("last mismatch: expected %0d, got %0d", want.last, lst);
				errors++;
			end
			if (ovf !== want.overflow) begin
				$error("overflow mismatch: expected %0d, got %0d", want.overflow, ovf);
				errors++;
			end
		endfunction

		function int pending();
			return finish_order.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;    // [9:0] job_id, [20:10] start_minute, [30:21] duration
	logic [0:0]  s_tuser = '0;    // [0] op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // [9:0] done_id
	logic        m_tlast;
	logic [0:0]  m_tuser;         // [0] overflow

	completion_tracker board;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycle_count = 0;
	int sched_minute = 0;

	preemptive_lifo_task_order #(
		.STACK_DEPTH(STACK_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver back-pressure.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Outputs are stable at the falling edge; a word seen there transfers at the next rise.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_done(m_tdata[ID_W-1:0], m_tlast, m_tuser[0]);
	end

	// Offers one word after any random idle cycles and waits until it is taken.
	task automatic put_word(kind_t op, logic [ID_W-1:0] id, logic [MIN_W-1:0] st,
		logic [DUR_W-1:0] dur);
		bit taken;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, dur, st, id};
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end
		board.note_item(op, id, st, dur);
	endtask

	task automatic flush_all();
		put_word(K_FLUSH, 10'($urandom), 11'($urandom_range(0, 1439)), 10'($urandom));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// Hand-picked jobs: empty flush, extremes, equal and earlier starts, partial resume.
	task automatic directed_jobs();
		flush_all();
		put_word(K_JOB, 10'd0, 11'd0, 10'd0);
		put_word(K_JOB, 10'd1023, 11'd0, 10'd1023);
		put_word(K_JOB, 10'd5, 11'd10, 10'd5);
		put_word(K_JOB, 10'd6, 11'd10, 10'd3);
		put_word(K_JOB, 10'd7, 11'd5, 10'd2);
		put_word(K_JOB, 10'd8, 11'd1439, 10'd1023);
		flush_all();
		put_word(K_JOB, 10'd20, 11'd100, 10'd50);
		put_word(K_JOB, 10'd21, 11'd110, 10'd10);
		put_word(K_JOB, 10'd22, 11'd130, 10'd5);
		put_word(K_JOB, 10'd23, 11'd165, 10'd1);
		flush_all();
		flush_all();
		put_word(K_JOB, 10'd30, 11'd0, 10'd100);
		put_word(K_JOB, 10'd31, 11'd1, 10'd100);
		put_word(K_JOB, 10'd682, 11'd1024, 10'd341);
		flush_all();
	endtask

	// Mostly rising start times with short jobs, so jobs both finish and preempt;
	// a few arbitrary starts, long or empty jobs, and flushes mixed in.
	task automatic random_jobs(int count);
		int r;
		int st;
		int dur;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 13)
				st = $urandom_range(0, 1439);
			else
				st = sched_minute + $urandom_range(0, 40);
			if (r < 8 || st > 1439) begin
				flush_all();
				sched_minute = $urandom_range(0, 1400);
			end else begin
				if ($urandom_range(0, 99) < 5)
					dur = 1023;
				else if ($urandom_range(0, 9) == 0)
					dur = 0;
				else
					dur = $urandom_range(1, 60);
				put_word(K_JOB, 10'($urandom), 11'(st), 10'(dur));
				if (r >= 13)
					sched_minute = st;
			end
		end
	endtask

	// Long jobs starting one minute apart fill the stack past its depth, then flush.
	task automatic deep_preemption();
		int base;
		base = $urandom_range(0, 1300);
		flush_all();
		for (int i = 0; i < STACK_DEPTH + 3; i++)
			put_word(K_JOB, 10'($urandom), 11'(base + i), 10'd1023);
		flush_all();
	endtask

	initial begin
		board = new(STACK_DEPTH);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 8;
		recv_idle_pct = 56;
		directed_jobs();
		random_jobs(18);
		wait_idle();

		send_idle_pct = 56;
		recv_idle_pct = 8;
		random_jobs(18);
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		deep_preemption();
		random_jobs(17);
		flush_all();
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> preemptive_lifo_task_order.f
+incdir+rtl/core
rtl/core/plto_pkg.sv
rtl/core/plto_front.sv
rtl/core/plto_back.sv
rtl/core/preemptive_lifo_task_order.sv
sim/tb.sv
